/* rtl/sem_pkg.sv */
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int unsigned PIX_W        = 24;
  localparam int unsigned CH_W         = 8;
  localparam int unsigned FW_W         = 11;
  localparam int unsigned FH_W         = 13;
  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned SUM_W        = 21;
  localparam logic [SUM_W-1:0] ROOT_CAP = 21'd65280;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GRAD,
    S_SQUARE,
    S_ROOT,
    S_HOLD
  } sem_state_e;

  typedef struct packed {
    logic       accept;
    logic       advance;
    logic       grad;
    logic       square;
    logic       root;
    logic [2:0] bit_idx;
    logic       load_out;
  } sem_cmd_t;

  typedef struct packed {
    logic ignore;
    logic produce;
    logic out_free;
  } sem_sts_t;

endpackage

/* rtl/sobel_edge_magnitude_rgb.sv */
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel gradient magnitude on RGB pixels, per channel.
// ----------------------------------------------------------------------------
// Input stream: pixels in raster order on s_axis; tuser high marks a drain
// transfer carrying no pixel. Once all pixels of a frame are in, drain
// transfers (or further pixels, whose value is dropped) flush the remaining
// results; a drain before the frame is complete is taken and dropped.
// Output stream: one result per pixel on m_axis, lagging the input by one row
// plus one pixel; tlast marks the frame's last result.
// A dropped drain is only accepted; any other transfer is accepted, then the
// registered line store read and window update follow, and when it yields a
// result also gradient, squares, then an 8-step square root per channel;
// the root unit sets the rate.
// The result sits in an output register; the next input transfer is taken
// while it waits, and the sequencer only stalls when a second result is
// ready before m_axis_tready takes the first.
// Reset (and any register write) restarts the frame at the top-left pixel;
// line stores hold no reset value and need no clearing.
// APB: register 0 at 0x0 is frame_width, register 1 at 0x4 frame_height.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // edge_red[7:0], edge_green[15:8], edge_blue[23:16]
  output logic        m_axis_tlast,   // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sem_pkg::*;

  sem_cmd_t        cmd;
  sem_sts_t        sts;
  logic            cfg_we;
  logic [FW_W-1:0] fw;
  logic [FH_W-1:0] fh;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(fh) : 32'(fw);

  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_pix_i       (s_axis_tdata),
    .in_op_i        (s_axis_tuser),
    .cfg_we_i       (cfg_we),
    .cfg_sel_i      (paddr[2]),
    .cfg_data_i     (pwdata),
    .frame_width_o  (fw),
    .frame_height_o (fh),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_pix_o      (m_axis_tdata),
    .out_last_o     (m_axis_tlast)
  );

endmodule

/* rtl/sem_ram.sv */
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sem_ctrl.sv */
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer: accept, line read/update, gradient, square, 8-step root, output.
// ----------------------------------------------------------------------------
module sem_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sem_pkg::sem_sts_t sts_i,
  output sem_pkg::sem_cmd_t cmd_o
);
  import sem_pkg::*;

  sem_state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.bit_idx = cnt_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && !sts_i.ignore) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.advance = 1'b1;
        state_d = sts_i.produce ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d    = S_SQUARE;
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        cnt_d        = 3'd7;
        state_d      = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root = 1'b1;
        cnt_d      = cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result loaded while output register busy");
  a_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT && cnt_q == 3'd0) |=> state_q == S_HOLD)
    else $error("root iteration did not finish after eight steps");
  a_accept_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && !sts_i.ignore) |=> state_q == S_READ)
    else $error("accepted item not processed");
`endif

endmodule

/* rtl/sem_datapath.sv */
// ----------------------------------------------------------------------------
// sem_datapath
// Line stores, 3x3 window, position counters, gradients, root and output reg.
// ----------------------------------------------------------------------------
module sem_datapath #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sem_pkg::sem_cmd_t          cmd_i,
  output sem_pkg::sem_sts_t          sts_o,
  input  logic [sem_pkg::PIX_W-1:0]  in_pix_i,
  input  logic                       in_op_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_sel_i,
  input  logic [31:0]                cfg_data_i,
  output logic [sem_pkg::FW_W-1:0]   frame_width_o,
  output logic [sem_pkg::FH_W-1:0]   frame_height_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sem_pkg::PIX_W-1:0]  out_pix_o,
  output logic                       out_last_o
);
  import sem_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [WW-1:0]   eff_w;
  logic [FH_W-1:0] eff_h;

  logic [AW-1:0]   col_q, ocol_q;
  logic [FH_W-1:0] row_q, orow_q;
  logic [PIX_W-1:0] pix_q;
  logic [2:0][2:0][PIX_W-1:0] win_q;
  logic [2:0][PIX_W-1:0] cols, cols_q;
  logic first_q, last_q;
  logic [2:0] rok_q, cok_q;
  logic [PIX_W-1:0] up_rd, mid_rd;

  logic complete, produce, col0, last_now, col_wrap;
  logic [2:0] rok_d, cok_d;

  logic signed [2:0][11:0] gx_q, gy_q;
  logic [2:0][SUM_W-1:0]   s_q;
  logic [2:0][7:0]         n_q;
  logic [2:0][15:0]        nsq_q;

  logic             out_valid_q, out_last_q;
  logic [PIX_W-1:0] out_pix_q;

  always_comb begin
    if (fw_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_q);
    end
    if (fh_q == '0) begin
      eff_h = FH_W'(1);
    end else if (32'(fh_q) > 32'(HEIGHT_LIMIT)) begin
      eff_h = FH_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = fh_q;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_W'(640);
      fh_q <= FH_W'(480);
    end else if (cfg_we_i) begin
      if (cfg_sel_i == REG_WIDTH) begin
        fw_q <= cfg_data_i[FW_W-1:0];
      end else begin
        fh_q <= cfg_data_i[FH_W-1:0];
      end
    end
  end

  assign frame_width_o  = fw_q;
  assign frame_height_o = fh_q;

  assign complete = row_q >= eff_h;
  assign produce  = (row_q >= FH_W'(2)) || (row_q == FH_W'(1) && col_q != '0);
  assign col0     = col_q == '0;
  assign col_wrap = (WW'(col_q) + WW'(1)) >= eff_w;

  assign rok_d[0] = orow_q != '0;
  assign rok_d[1] = 1'b1;
  assign rok_d[2] = (orow_q + FH_W'(1)) < eff_h;
  assign cok_d[0] = ocol_q != '0;
  assign cok_d[1] = 1'b1;
  assign cok_d[2] = (WW'(ocol_q) + WW'(1)) < eff_w;
  assign last_now = (orow_q == eff_h - FH_W'(1)) && (WW'(ocol_q) == eff_w - WW'(1));

  assign sts_o.ignore   = (in_op_i == OP_DRAIN) && !complete;
  assign sts_o.produce  = produce;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // row stores: upper holds two rows back, middle one row back
  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (cmd_i.advance),
    .waddr_i (col_q),
    .wdata_i (mid_rd),
    .re_i    (cmd_i.accept),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (cmd_i.advance),
    .waddr_i (col_q),
    .wdata_i (pix_q),
    .re_i    (cmd_i.accept),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  assign cols[0] = up_rd;
  assign cols[1] = mid_rd;
  assign cols[2] = pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= complete ? '0 : in_pix_i;
    end
    if (cmd_i.advance) begin
      cols_q  <= cols;
      first_q <= col0;
      rok_q   <= rok_d;
      cok_q   <= cok_d;
      last_q  <= last_now;
    end
  end

  // position counters and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      win_q  <= '0;
    end else if (cfg_we_i) begin
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      win_q  <= '0;
    end else if (cmd_i.advance) begin
      for (int i = 0; i < 3; i++) begin
        if (!produce && col0) begin
          win_q[i][0] <= '0;
          win_q[i][1] <= '0;
          win_q[i][2] <= cols[i];
        end else begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
          win_q[i][2] <= col0 ? '0 : cols[i];
        end
      end
      if (produce && last_now) begin
        col_q  <= '0;
        row_q  <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_q + FH_W'(1);
        end else begin
          col_q <= col_q + AW'(1);
        end
        if (produce) begin
          if ((WW'(ocol_q) + WW'(1)) >= eff_w) begin
            ocol_q <= '0;
            orow_q <= orow_q + FH_W'(1);
          end else begin
            ocol_q <= ocol_q + AW'(1);
          end
        end
      end
    end else if (cmd_i.grad) begin
      // window fixup happens after the gradient has seen the shifted window
      if (last_q) begin
        win_q <= '0;
      end else if (first_q) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= '0;
          win_q[i][1] <= '0;
          win_q[i][2] <= cols_q[i];
        end
      end
    end
  end

  // gradient, square and root lanes, one per channel
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [2:0][2:0][11:0] v;
      logic [10:0] ax, ay;
      logic [16:0] tsq;
      logic [7:0]  t;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          v[i][k] = (rok_q[i] && cok_q[k]) ?
                    12'(win_q[i][k][ch*CH_W +: CH_W]) : 12'sd0;
        end
      end
      ax  = gx_q[ch][11] ? 11'(-gx_q[ch]) : 11'(gx_q[ch]);
      ay  = gy_q[ch][11] ? 11'(-gy_q[ch]) : 11'(gy_q[ch]);
      t   = n_q[ch] | (8'd1 << cmd_i.bit_idx);
      tsq = 17'(nsq_q[ch]) + (17'(n_q[ch]) << (4'(cmd_i.bit_idx) + 4'd1))
            + (17'd1 << (5'(cmd_i.bit_idx) << 1));
      if (cmd_i.grad) begin
        gx_q[ch] <= (v[0][2] + (v[1][2] <<< 1) + v[2][2])
                  - (v[0][0] + (v[1][0] <<< 1) + v[2][0]);
        gy_q[ch] <= (v[2][0] + (v[2][1] <<< 1) + v[2][2])
                  - (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
      end
      if (cmd_i.square) begin
        s_q[ch]   <= SUM_W'(ax * ax) + SUM_W'(ay * ay);
        n_q[ch]   <= '0;
        nsq_q[ch] <= '0;
      end else if (cmd_i.root) begin
        if (SUM_W'(tsq) <= s_q[ch]) begin
          n_q[ch]   <= t;
          nsq_q[ch] <= tsq[15:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_last_q <= last_q;
      for (int ch = 0; ch < 3; ch++) begin
        if (s_q[ch] > ROOT_CAP) begin
          out_pix_q[ch*CH_W +: CH_W] <= 8'hFF;
        end else if (s_q[ch] > (SUM_W'(nsq_q[ch]) + SUM_W'(n_q[ch]))) begin
          out_pix_q[ch*CH_W +: CH_W] <= n_q[ch] + 8'd1;
        end else begin
          out_pix_q[ch*CH_W +: CH_W] <= n_q[ch];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign out_last_o  = out_last_q;

endmodule

/* verif/tb_sobel_edge_magnitude_rgb.sv */
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_rgb
// Self-checking bench for the RGB Sobel edge magnitude block. Frames of many
// sizes are streamed in, whole with flush drains or partial and abandoned.
// A built-in predictor works out every edge result, and the monitor checks
// the results in order. Both stream sides idle at random; APB sets the frame size.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_rgb;
  import sem_pkg::*;

  localparam int unsigned LINE_MAX  = 1024;
  localparam int unsigned STALL_MAX = 3000;

  typedef struct {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_item_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } edge_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red_in[7:0], green_in[15:8], blue_in[23:16]
  logic        s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // edge_red[7:0], edge_green[15:8], edge_blue[23:16]
  logic        m_axis_tlast;   // frame_end
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sobel_edge_magnitude_rgb dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pixel_item_t pixel_q[$];
  edge_item_t  edge_q[$];
  int unsigned mismatches;
  int unsigned fed_items;
  int unsigned hold_req;
  bit          took;

  // predictor state
  logic [10:0] cfg_width;
  logic [12:0] cfg_height;
  logic [23:0] upper_line[LINE_MAX];
  logic [23:0] middle_line[LINE_MAX];
  logic [23:0] win[3][3];
  int unsigned col_pos, row_pos, emit_cnt;

  int kx[3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  int ky[3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cfg_width;
    if (w == 0) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = cfg_height;
    if (h == 0) h = 1;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    return h;
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    emit_cnt = 0;
    foreach (win[i, k]) win[i][k] = '0;
  endfunction

  // rounded integer square root, saturating at 255
  function automatic logic [7:0] rounded_root(int unsigned s);
    int unsigned n, t;
    if (s > 65280) return 8'hFF;
    n = 0;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = n + b;
      if (t * t <= s) n = t;
    end
    if (s > n * n + n) n++;
    return n[7:0];
  endfunction

  function automatic logic [7:0] channel_mag(int sh, bit rok[3], bit cok[3]);
    int gx, gy, v;
    gx = 0;
    gy = 0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (rok[i] && cok[k]) begin
          v = int'((win[i][k] >> sh) & 24'hFF);
          gx += v * kx[i][k];
          gy += v * ky[i][k];
        end
      end
    end
    return rounded_root(gx * gx + gy * gy);
  endfunction

  // advance the predicted block by one accepted transfer
  function automatic void predict_edge(pixel_item_t it);
    int unsigned w, h, total, c, p, q, orow, ocol;
    bit          complete, produce;
    bit          rok[3], cok[3];
    logic [23:0] pix;
    logic [23:0] colv[3];
    edge_item_t  e;
    w = eff_width();
    h = eff_height();
    total = w * h;
    c = col_pos;
    p = row_pos * w + c;
    complete = p >= total;
    if (it.op == OP_DRAIN && !complete) return;
    pix = complete ? 24'h0 : {it.red, it.green, it.blue};
    if (c >= LINE_MAX) c = LINE_MAX - 1;
    colv[0] = upper_line[c];
    colv[1] = middle_line[c];
    colv[2] = pix;
    upper_line[c] = middle_line[c];
    middle_line[c] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
      win[i][2] = (col_pos == 0) ? 24'h0 : colv[i];
    end
    produce = p >= w + 1;
    if (produce) begin
      q = emit_cnt;
      orow = q / w;
      ocol = q % w;
      rok = '{orow >= 1, 1'b1, orow + 1 < h};
      cok = '{ocol >= 1, 1'b1, ocol + 1 < w};
      e.red = channel_mag(16, rok, cok);
      e.green = channel_mag(8, rok, cok);
      e.blue = channel_mag(0, rok, cok);
      e.last = (q + 1 == total);
      edge_q.push_back(e);
    end
    if (col_pos == 0) begin
      foreach (win[i, k]) win[i][k] = '0;
      for (int i = 0; i < 3; i++) win[i][2] = colv[i];
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (produce) begin
      emit_cnt++;
      if (emit_cnt >= total) restart_frame();
    end
  endfunction

  task automatic apb_write(logic reg_sel, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (reg_sel == REG_WIDTH) cfg_width = value[10:0];
    else cfg_height = value[12:0];
    restart_frame();
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pixel_q.size() != 0 || s_axis_tvalid || edge_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic push_pixel(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_item_t it;
    it.op = op;
    it.red = r;
    it.green = g;
    it.blue = b;
    pixel_q.push_back(it);
    fed_items++;
  endtask

  task automatic push_random(logic op);
    push_pixel(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
  endtask

  // whole frame plus its flush; content: 0 random, 1 extremes checker
  task automatic send_frame(int unsigned w, int unsigned h, int style);
    logic [7:0] v;
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        if (style == 1) begin
          v = ((x + y) % 2) ? 8'hFF : 8'h00;
          push_pixel(OP_PIXEL, v, ~v, v);
        end else begin
          push_random(OP_PIXEL);
          // stray drain, dropped by the block unless it follows the frame's last pixel
          if ($urandom_range(0, 40) == 0) push_random(OP_DRAIN);
        end
      end
    end
    // flush; a pixel after frame completion behaves as a drain
    for (int unsigned i = 0; i <= w; i++)
      push_random(($urandom_range(0, 5) == 0) ? OP_PIXEL : OP_DRAIN);
  endtask

  task automatic set_size(logic [31:0] w, logic [31:0] h);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
  endtask

  // driver: bursts of random length with random gaps
  int unsigned burst_left, gap_left;
  always @(negedge clk_i) begin
    if (!(s_axis_tvalid && !took)) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pixel_q[0].op;
        s_axis_tdata <= {pixel_q[0].blue, pixel_q[0].green, pixel_q[0].red};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    took = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_edge(pixel_q.pop_front());
      took = 1'b1;
    end
  end

  // receiver: stall pattern with its own phases, plus long hold-offs on request
  int unsigned rx_mode_left, rx_mode, rx_hold;
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      rx_hold = hold_req;
      hold_req = 0;
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(10, 80);
    end
    rx_mode_left--;
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    edge_item_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (edge_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: data %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        e = edge_q.pop_front();
        if (m_axis_tdata !== {e.blue, e.green, e.red} || m_axis_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("edge mismatch: expected r %h g %h b %h last %b, got data %h last %b",
                     e.red, e.green, e.blue, e.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned w, h, n;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    fed_items = 0;
    hold_req = 0;
    took = 1'b0;
    burst_left = 0;
    gap_left = 0;
    rx_mode_left = 0;
    rx_hold = 0;
    quiet_cycles = 0;
    cfg_width = 11'd640;
    cfg_height = 13'd480;
    foreach (upper_line[i]) upper_line[i] = '0;
    foreach (middle_line[i]) middle_line[i] = '0;
    restart_frame();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset size: partial frame, then abandon it
    push_random(OP_DRAIN);
    repeat (643) push_random(OP_PIXEL);
    wait_idle();

    // directed: extremes checkerboard, zero sizes, single row, single column
    set_size(3, 3);
    push_pixel(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    send_frame(3, 3, 1);
    wait_idle();
    set_size(0, 0);
    send_frame(1, 1, 1);
    wait_idle();
    set_size(4, 1);
    send_frame(4, 1, 0);
    wait_idle();
    set_size(1, 5);
    send_frame(1, 5, 1);
    wait_idle();

    // widest line (saturated width) and saturated height, abandoned early
    set_size(32'h7FF, 32'h1FFF);
    repeat (1027) push_random(OP_PIXEL);
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    set_size(8, 4);
    hold_req = 400;
    send_frame(8, 4, 0);
    wait_idle();

    // random frames, mostly small
    while (fed_items < 1900) begin
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 12);
      h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 8);
      if ($urandom_range(0, 1)) set_size(w, h);
      else if ($urandom_range(0, 1)) apb_write(REG_WIDTH, w);
      else apb_write(REG_HEIGHT, h);
      if ($urandom_range(0, 20) == 0) hold_req = $urandom_range(200, 400);
      w = eff_width();
      h = eff_height();
      if (w * h > 150) begin
        n = $urandom_range(0, 60);
        repeat (n) push_random($urandom_range(0, 9) == 0 ? OP_DRAIN : OP_PIXEL);
      end else if ($urandom_range(0, 9) == 0) begin
        // broken frame, abandoned by the next register write
        n = $urandom_range(0, w * h);
        repeat (n) push_random(OP_PIXEL);
      end else begin
        send_frame(w, h, 0);
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
